// File: design/sec_pkg.sv
`default_nettype none

package sec_pkg;

    localparam int NUM_SOURCES_DEF = 4;
    localparam int SRC_W           = 3;
    localparam int MS_W            = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [MS_W-1:0] SLEEP_DELAY_RST = 16'd5000;
    localparam logic [MS_W-1:0] ACTIVE_THR_RST  = 16'd300;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_SLEEP_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THR    = 2'd2;

    typedef enum logic [1:0] {
        CMD_SET_VOTE = 2'd0,
        CMD_WAKEUP   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_CHECK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        VOTE_UNKNOWN  = 2'd0,
        VOTE_SUPPRESS = 2'd1,
        VOTE_ALLOW    = 2'd2
    } t_vote;

    typedef struct packed {
        logic            deep_sleep_en;
        logic [MS_W-1:0] sleep_delay_ms;
        logic [MS_W-1:0] active_thr_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd             command;
        logic [SRC_W-1:0] source_index;
        logic             suppress_flag;
        logic             tick_from_standby;
        logic [MS_W-1:0]  tick_interval_ms;
        logic             battery_critical;
        logic             battery_measuring;
    } t_item;

    typedef struct packed {
        logic enter_sleep;
        logic watchdog_update;
        logic watchdog_standby;
    } t_result;

endpackage

`default_nettype wire

// File: design/sec_cfg_regs.sv
`default_nettype none

module sec_cfg_regs
    import sec_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MS_W-1:0]      i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deep_sleep_en  <= 1'b1;
            r_cfg.sleep_delay_ms <= SLEEP_DELAY_RST;
            r_cfg.active_thr_ms  <= ACTIVE_THR_RST;
        end else if (i_cfg_valid) begin
            priority if (i_cfg_index == REG_DEEP_SLEEP_EN) begin
                r_cfg.deep_sleep_en <= i_cfg_data[0];
            end else if (i_cfg_index == REG_SLEEP_DELAY) begin
                r_cfg.sleep_delay_ms <= i_cfg_data;
            end else if (i_cfg_index == REG_ACTIVE_THR) begin
                r_cfg.active_thr_ms <= i_cfg_data;
            end else begin
                // unused index, write dropped
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/sec_core.sv
`default_nettype none

module sec_core
    import sec_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic [MS_W-1:0] r_active_ms, n_active_ms;
    logic [MS_W-1:0] r_delay_ms, n_delay_ms;
    t_vote           r_votes [NUM_SOURCES];
    t_vote           n_votes [NUM_SOURCES];
    logic            r_prev_possible, n_prev_possible;

    logic            all_allow;
    logic            none_unknown;
    logic [MS_W:0]   active_sum;
    logic [MS_W-1:0] delay_armed;
    logic            arm;

    always_comb begin
        all_allow    = 1'b1;
        none_unknown = 1'b1;
        for (int k = 0; k < NUM_SOURCES; k++) begin
            all_allow    = all_allow && (r_votes[k] == VOTE_ALLOW);
            none_unknown = none_unknown && (r_votes[k] != VOTE_UNKNOWN);
        end
    end

    assign active_sum  = {1'b0, r_active_ms} + {1'b0, i_item.tick_interval_ms};
    // arm the delay on the rising edge of standby-possible, once the active time has reached the threshold
    assign arm         = all_allow && !r_prev_possible &&
                         (r_active_ms >= i_cfg.active_thr_ms);
    assign delay_armed = arm ? i_cfg.sleep_delay_ms : r_delay_ms;

    always_comb begin
        n_active_ms     = r_active_ms;
        n_delay_ms      = r_delay_ms;
        n_prev_possible = r_prev_possible;
        for (int k = 0; k < NUM_SOURCES; k++) begin
            n_votes[k] = r_votes[k];
        end
        o_result = '0;
        if (i_fire && i_cfg.deep_sleep_en) begin
            unique case (i_item.command)
                CMD_SET_VOTE: begin
                    for (int k = 0; k < NUM_SOURCES; k++) begin
                        if (i_item.source_index == SRC_W'(k)) begin
                            n_votes[k] = i_item.suppress_flag ? VOTE_SUPPRESS : VOTE_ALLOW;
                        end
                    end
                end
                CMD_WAKEUP: begin
                    n_active_ms = '0;
                    for (int k = 0; k < NUM_SOURCES; k++) begin
                        n_votes[k] = VOTE_UNKNOWN;
                    end
                end
                CMD_TICK: begin
                    if (!i_item.tick_from_standby) begin
                        n_active_ms = active_sum[MS_W] ? '1 : active_sum[MS_W-1:0];
                    end
                    if (all_allow) begin
                        n_delay_ms = (r_delay_ms > i_item.tick_interval_ms) ?
                                     r_delay_ms - i_item.tick_interval_ms : '0;
                    end
                end
                CMD_CHECK: begin
                    n_delay_ms      = delay_armed;
                    n_prev_possible = all_allow;
                    o_result.enter_sleep = (all_allow && (delay_armed == '0)) ||
                                           (i_item.battery_critical &&
                                            !i_item.battery_measuring);
                    o_result.watchdog_update  = none_unknown;
                    o_result.watchdog_standby = none_unknown && all_allow;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_ms     <= '0;
            r_delay_ms      <= '0;
            r_prev_possible <= 1'b0;
            for (int k = 0; k < NUM_SOURCES; k++) begin
                r_votes[k] <= VOTE_UNKNOWN;
            end
        end else begin
            r_active_ms     <= n_active_ms;
            r_delay_ms      <= n_delay_ms;
            r_prev_possible <= n_prev_possible;
            for (int k = 0; k < NUM_SOURCES; k++) begin
                r_votes[k] <= n_votes[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/standby_entry_coordinator.sv
// channel | dir | handshake                | payload
// in      | in  | i_in_valid / o_in_ready  | command, source_index, suppress_flag,
//         |     |                          | tick_from_standby, tick_interval_ms,
//         |     |                          | battery_critical, battery_measuring
// out     | out | o_out_valid / i_out_ready| enter_sleep, watchdog_update, watchdog_standby
// cfg     | in  | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while results are taken; a request sits in the
// input register, is evaluated against the vote/timer state and lands in the result
// register while the state updates. Synchronous active-low reset clears the valid
// flags and the vote/timer state and loads the register defaults.
// A stalled result holds the result register; the input register still takes a new
// request whenever the held one can move on in the same cycle.
`default_nettype none

module standby_entry_coordinator
    import sec_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_command,
    input  wire logic [SRC_W-1:0]     i_source_index,
    input  wire logic                 i_suppress_flag,
    input  wire logic                 i_tick_from_standby,
    input  wire logic [MS_W-1:0]      i_tick_interval_ms,
    input  wire logic                 i_battery_critical,
    input  wire logic                 i_battery_measuring,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_enter_sleep,
    output logic                      o_watchdog_update,
    output logic                      o_watchdog_standby,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [MS_W-1:0]      i_cfg_data
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    t_cfg    cfg;
    logic    fire;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.command           <= t_cmd'(i_command);
            r_item.source_index      <= i_source_index;
            r_item.suppress_flag     <= i_suppress_flag;
            r_item.tick_from_standby <= i_tick_from_standby;
            r_item.tick_interval_ms  <= i_tick_interval_ms;
            r_item.battery_critical  <= i_battery_critical;
            r_item.battery_measuring <= i_battery_measuring;
        end
    end

    sec_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sec_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_enter_sleep      = r_result.enter_sleep;
    assign o_watchdog_update  = r_result.watchdog_update;
    assign o_watchdog_standby = r_result.watchdog_standby;

    a_standby_needs_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_watchdog_standby |-> o_watchdog_update)
        else $error("watchdog_standby without watchdog_update");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !cfg.deep_sleep_en |=>
            !o_enter_sleep && !o_watchdog_update && !o_watchdog_standby)
        else $error("nonzero result while deep sleep disabled");

    a_non_check_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_item.command != CMD_CHECK) |=>
            !o_enter_sleep && !o_watchdog_update && !o_watchdog_standby)
        else $error("nonzero result for non-check request");

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

endmodule

`default_nettype wire
